// ===== design/mptg_pkg.sv =====
// shared types, constants and register indexes for the pulse train generator
package mptg_pkg;

  // block size
  localparam int CHANNELS    = 4;
  localparam int TIME_BITS   = 16;
  localparam int PERIOD_BITS = 18;
  localparam int LANE_BITS   = 16;
  localparam int CFG_BITS    = 64;
  localparam int QUEUE_DEPTH = 2;

  // saturation limits
  localparam logic [TIME_BITS-1:0]   TIME_MAX   = {TIME_BITS{1'b1}};
  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = {PERIOD_BITS{1'b1}};

  // command codes
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // event action codes
  localparam logic [1:0] ACT_DRIVE_ZERO = 2'd0;
  localparam logic [1:0] ACT_DRIVE_AMP  = 2'd1;
  localparam logic [1:0] ACT_FLOAT      = 2'd2;
  localparam logic [1:0] ACT_FLOAT_ALL  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_ZERO_FIRST  = 3'd0;
  localparam logic [2:0] REG_ACTIVE      = 3'd1;
  localparam logic [2:0] REG_ZERO_SECOND = 3'd2;
  localparam logic [2:0] REG_BURST       = 3'd3;
  localparam logic [2:0] REG_AMPLITUDE   = 3'd4;
  localparam logic [2:0] REG_ENABLE      = 3'd5;

  // one tick
  typedef struct packed {
    logic [1:0] command;
    logic       restart;
  } in_item_t;

  // one event
  typedef struct packed {
    logic [1:0]  channel;
    logic [1:0]  action;
    logic [15:0] drive_value;
    logic        running;
    logic        last;
  } out_item_t;

  // all events of one tick, slot c belongs to channel c
  typedef struct packed {
    logic [CHANNELS-1:0]                valid;
    logic [CHANNELS-1:0][1:0]           action;
    logic [CHANNELS-1:0][LANE_BITS-1:0] value;
    logic                               running;
  } tick_rec_t;

endpackage

// ===== design/multichannel_pulse_train_generator_top.sv =====
// top level of the multichannel pulse train generator
//
//   port group       direction  handshake          contents
//   item             in         push / full        command, restart
//   result           out        empty / pop        channel, action, value, flags
//   cfg_*            in         cfg_write          register index and data
//
// a tick is taken whenever the record queue has room; ticks may follow back
// to back. each tick yields zero to four events, sent one per cycle by the
// back end while the result side keeps popping. reset is synchronous and
// clears run state, counters and queues; a stalled result side fills the
// two-record queue and then raises full.
module multichannel_pulse_train_generator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  mptg_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output mptg_pkg::out_item_t result,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import mptg_pkg::*;

  tick_rec_t front_rec;
  tick_rec_t q_rec;
  logic      rec_push;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;

  assign full = q_full;

  // tick front end
  mptg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (q_full),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rec_push  (rec_push),
    .rec       (front_rec)
  );

  // record queue
  mptg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (rec_push),
    .wr_rec   (front_rec),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_rec   (q_rec)
  );

  // event back end
  mptg_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_rec   (q_rec),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== design/mptg_front.sv =====
// tick front end: channel state update and event classification
module mptg_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  mptg_pkg::in_item_t item,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               rec_push,
  output mptg_pkg::tick_rec_t rec
);
  import mptg_pkg::*;

  typedef enum logic [1:0] {
    PH_FLOAT = 2'd0,
    PH_ZERO1 = 2'd1,
    PH_ACTIVE = 2'd2,
    PH_ZERO2 = 2'd3
  } phase_t;

  // configuration
  logic [CFG_BITS-1:0] zero_first_times;
  logic [CFG_BITS-1:0] active_times;
  logic [CFG_BITS-1:0] zero_second_times;
  logic [CFG_BITS-1:0] burst_durations;
  logic [CFG_BITS-1:0] amplitudes;
  logic [CHANNELS-1:0] channel_enable;

  // channel state
  logic [CHANNELS-1:0][TIME_BITS-1:0]   dur;
  logic [CHANNELS-1:0][PERIOD_BITS-1:0] per;
  phase_t                               phase [CHANNELS];
  logic                                 run_flag;
  logic                                 prev_flag;

  logic [CHANNELS-1:0][TIME_BITS-1:0]   dur_next;
  logic [CHANNELS-1:0][PERIOD_BITS-1:0] per_next;
  phase_t                               phase_next [CHANNELS];
  logic                                 run_next;
  logic                                 prev_next;
  logic                                 accept;

  assign accept = push && !full;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_first_times  <= '0;
      active_times      <= '0;
      zero_second_times <= '0;
      burst_durations   <= '0;
      amplitudes        <= '0;
      channel_enable    <= {CHANNELS{1'b1}};
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ZERO_FIRST:  zero_first_times  <= cfg_data;
        REG_ACTIVE:      active_times      <= cfg_data;
        REG_ZERO_SECOND: zero_second_times <= cfg_data;
        REG_BURST:       burst_durations   <= cfg_data;
        REG_AMPLITUDE:   amplitudes        <= cfg_data;
        REG_ENABLE:      channel_enable    <= cfg_data[CHANNELS-1:0];
        default: ;
      endcase
    end
  end

  // next channel state and events for the offered tick
  always_comb begin
    logic                     run_cmd;
    logic                     prev_rst;
    logic                     any_run;
    logic                     stop_edge;
    logic [TIME_BITS-1:0]     dur_base;
    logic [PERIOD_BITS-1:0]   per_base;
    logic [TIME_BITS-1:0]     t1;
    logic [TIME_BITS-1:0]     ta;
    logic [TIME_BITS-1:0]     t2;
    logic [TIME_BITS-1:0]     bd;
    logic [TIME_BITS:0]       e2;
    logic [TIME_BITS+1:0]     e3;
    phase_t                   nxt;

    run_cmd = run_flag;
    if (item.command == CMD_START) begin
      run_cmd = 1'b1;
    end else if (item.command == CMD_STOP) begin
      run_cmd = 1'b0;
    end
    prev_rst  = item.restart ? !run_cmd : prev_flag;
    stop_edge = !run_cmd && (prev_rst != run_cmd);
    any_run   = 1'b0;
    rec       = '0;

    for (int c = 0; c < CHANNELS; c++) begin
      dur_base = item.restart ? '0 : dur[c];
      per_base = item.restart ? '0 : per[c];
      t1 = zero_first_times[LANE_BITS*c +: TIME_BITS];
      ta = active_times[LANE_BITS*c +: TIME_BITS];
      t2 = zero_second_times[LANE_BITS*c +: TIME_BITS];
      bd = burst_durations[LANE_BITS*c +: TIME_BITS];
      e2 = {1'b0, t1} + {1'b0, ta};
      e3 = {1'b0, e2} + {2'b00, t2};
      nxt = PH_FLOAT;
      dur_next[c]   = dur_base;
      per_next[c]   = per_base;
      phase_next[c] = phase[c];
      if (run_cmd) begin
        if (dur_base != TIME_MAX) begin
          dur_base = dur_base + 1'b1;
        end
        if (per_base != PERIOD_MAX) begin
          per_base = per_base + 1'b1;
        end
        if (channel_enable[c] && (dur_base < bd)) begin
          any_run = 1'b1;
          if (per_base >= PERIOD_BITS'(e3)) begin
            per_base = '0;
          end
          if (per_base >= PERIOD_BITS'(e2)) begin
            nxt = PH_ZERO2;
          end else if (per_base >= PERIOD_BITS'(t1)) begin
            nxt = PH_ACTIVE;
          end else begin
            nxt = PH_ZERO1;
          end
        end
        dur_next[c]   = dur_base;
        per_next[c]   = per_base;
        phase_next[c] = nxt;
        // phase change gives one event
        if (nxt != phase[c]) begin
          rec.valid[c] = 1'b1;
          if (nxt == PH_ACTIVE) begin
            rec.action[c] = ACT_DRIVE_AMP;
            rec.value[c]  = amplitudes[LANE_BITS*c +: LANE_BITS];
          end else if (nxt == PH_FLOAT) begin
            rec.action[c] = ACT_FLOAT;
          end else begin
            rec.action[c] = ACT_DRIVE_ZERO;
          end
        end
      end else if (stop_edge) begin
        dur_next[c]   = '0;
        per_next[c]   = '0;
        phase_next[c] = PH_FLOAT;
      end
    end

    // run flags and the float-all event
    if (run_cmd) begin
      prev_next = 1'b1;
      run_next  = any_run;
    end else if (stop_edge) begin
      prev_next       = run_cmd;
      run_next        = run_cmd;
      rec.valid[0]    = 1'b1;
      rec.action[0]   = ACT_FLOAT_ALL;
    end else begin
      prev_next = prev_rst;
      run_next  = run_cmd;
    end
    rec.running = run_next;
  end

  assign rec_push = accept && (|rec.valid);

  // state update on each tick transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag  <= 1'b0;
      prev_flag <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        dur[c]   <= '0;
        per[c]   <= '0;
        phase[c] <= PH_FLOAT;
      end
    end else if (accept) begin
      run_flag  <= run_next;
      prev_flag <= prev_next;
      for (int c = 0; c < CHANNELS; c++) begin
        dur[c]   <= dur_next[c];
        per[c]   <= per_next[c];
        phase[c] <= phase_next[c];
      end
    end
  end

  // a running generator has always seen its run edge
  a_run_implies_prev: assert property (@(posedge clk) disable iff (rst)
    run_flag |-> prev_flag)
    else $error("run flag set without previous run flag");

endmodule

// ===== design/mptg_queue.sv =====
// short queue of per-tick event records between front and back
module mptg_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  mptg_pkg::tick_rec_t wr_rec,
  output logic                full,
  input  logic                rd_en,
  output logic                rd_valid,
  output mptg_pkg::tick_rec_t rd_rec
);
  import mptg_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  tick_rec_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == CNT_FULL);
  assign rd_valid = (count != '0);
  assign rd_rec   = entries[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count beyond depth");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("record written into full queue");

endmodule

// ===== design/mptg_back.sv =====
// event back end: serializes records into single event transfers
module mptg_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  mptg_pkg::tick_rec_t  q_rec,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output mptg_pkg::out_item_t  result
);
  import mptg_pkg::*;

  tick_rec_t           cur;
  logic [CHANNELS-1:0] pend;
  logic                out_full;
  out_item_t           out_q;

  logic [CHANNELS-1:0] sel_oh;
  logic [1:0]          sel_ch;
  logic [1:0]          sel_act;
  logic [LANE_BITS-1:0] sel_val;
  logic [CHANNELS-1:0] pend_after;
  logic                out_take;
  logic                emit;

  // lowest pending channel goes next
  always_comb begin
    sel_oh  = '0;
    sel_ch  = '0;
    sel_act = '0;
    sel_val = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (pend[c]) begin
        sel_oh    = '0;
        sel_oh[c] = 1'b1;
        sel_ch    = 2'(c);
        sel_act   = cur.action[c];
        sel_val   = cur.value[c];
      end
    end
  end

  assign out_take   = pop && out_full;
  assign emit       = (|pend) && (!out_full || out_take);
  assign pend_after = pend & ~sel_oh;
  assign q_pop      = q_valid && ((pend == '0) || (emit && (pend_after == '0)));
  assign empty      = !out_full;
  assign result     = out_q;

  // current record and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= '0;
      out_full <= 1'b0;
    end else begin
      if (emit) begin
        out_full          <= 1'b1;
        out_q.channel     <= sel_ch;
        out_q.action      <= sel_act;
        out_q.drive_value <= sel_val;
        out_q.running     <= cur.running;
        out_q.last        <= (pend_after == '0);
      end else if (out_take) begin
        out_full <= 1'b0;
      end
      if (q_pop) begin
        cur  <= q_rec;
        pend <= q_rec.valid;
      end else if (emit) begin
        pend <= pend_after;
      end
    end
  end

  a_float_all_alone: assert property (@(posedge clk) disable iff (rst)
    (out_full && (out_q.action == ACT_FLOAT_ALL)) |-> out_q.last)
    else $error("float-all event not last of its tick");

endmodule

// ===== dv/mptg_tb_pkg.sv =====
// event predictor and scoreboard for the pulse train generator testbench
package mptg_tb_pkg;
  import mptg_pkg::*;

  // tick commands with no name in the design package
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // per-channel phase
  typedef enum logic [1:0] {
    PH_FLOAT  = 2'd0,
    PH_ZERO1  = 2'd1,
    PH_ACTIVE = 2'd2,
    PH_ZERO2  = 2'd3
  } chan_phase_t;

  class pulse_event_scoreboard;
    // register copies
    logic [CFG_BITS-1:0] zero_first, active, zero_second, burst, amplitude;
    logic [CHANNELS-1:0] enable;

    // channel state copies
    logic [TIME_BITS-1:0]   dur_count [CHANNELS];
    logic [PERIOD_BITS-1:0] per_count [CHANNELS];
    chan_phase_t            phase [CHANNELS];
    bit                     run_flag, run_seen;

    out_item_t   expected_events[$];
    int unsigned mismatches;

    function new();
      zero_first  = '0;
      active      = '0;
      zero_second = '0;
      burst       = '0;
      amplitude   = '0;
      enable      = '1;
      clear_counters();
      foreach (phase[c]) phase[c] = PH_FLOAT;
      run_flag    = 1'b0;
      run_seen    = 1'b0;
      mismatches  = 0;
    endfunction

    function int unsigned lane(logic [CFG_BITS-1:0] r, int c);
      return int'((r >> (LANE_BITS * c)) & 64'hFFFF);
    endfunction

    function void clear_counters();
      foreach (dur_count[c]) begin
        dur_count[c] = '0;
        per_count[c] = '0;
      end
    endfunction

    // register write transfer
    function void note_config(logic [2:0] idx, logic [CFG_BITS-1:0] data);
      case (idx)
        REG_ZERO_FIRST:  zero_first  = data;
        REG_ACTIVE:      active      = data;
        REG_ZERO_SECOND: zero_second = data;
        REG_BURST:       burst       = data;
        REG_AMPLITUDE:   amplitude   = data;
        REG_ENABLE:      enable      = data[CHANNELS-1:0];
        default: ;
      endcase
    endfunction

    // accepted tick: advance the channel state and queue the events it causes
    function void note_tick(in_item_t tick);
      out_item_t   evs[$];
      out_item_t   ev;
      chan_phase_t nxt;
      bit          any_live;
      int unsigned t1, ta, t2, bd, end_active, end_period;
      if (tick.command == CMD_START) run_flag = 1'b1;
      else if (tick.command == CMD_STOP) run_flag = 1'b0;
      // restart zeroes counters and forces the run-edge path
      if (tick.restart) begin
        run_seen = !run_flag;
        clear_counters();
      end
      if (run_flag) begin
        any_live = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
          nxt = PH_FLOAT;
          if (dur_count[c] != TIME_MAX) dur_count[c]++;
          if (per_count[c] != PERIOD_MAX) per_count[c]++;
          if (enable[c]) begin
            t1 = lane(zero_first, c) & TIME_MAX;
            ta = lane(active, c) & TIME_MAX;
            t2 = lane(zero_second, c) & TIME_MAX;
            bd = lane(burst, c) & TIME_MAX;
            if (dur_count[c] < bd) begin
              any_live   = 1'b1;
              end_active = t1 + ta;
              end_period = end_active + t2;
              if (per_count[c] >= end_period) per_count[c] = '0;
              if (per_count[c] >= end_active) nxt = PH_ZERO2;
              else if (per_count[c] >= t1) nxt = PH_ACTIVE;
              else nxt = PH_ZERO1;
            end
          end
          // one event per phase change
          if (nxt != phase[c]) begin
            ev = '0;
            ev.channel = 2'(c);
            if (nxt == PH_ACTIVE) begin
              ev.action      = ACT_DRIVE_AMP;
              ev.drive_value = 16'(lane(amplitude, c));
            end else if (nxt == PH_FLOAT) begin
              ev.action = ACT_FLOAT;
            end else begin
              ev.action = ACT_DRIVE_ZERO;
            end
            evs.push_back(ev);
          end
          phase[c] = nxt;
        end
        run_seen = 1'b1;
        if (!any_live) run_flag = 1'b0;
      end else if (run_seen != run_flag) begin
        // falling run edge: everything floats
        run_seen = run_flag;
        clear_counters();
        foreach (phase[c]) phase[c] = PH_FLOAT;
        ev = '0;
        ev.action = ACT_FLOAT_ALL;
        evs.push_back(ev);
      end
      foreach (evs[k]) begin
        evs[k].running = run_flag;
        evs[k].last    = (k == evs.size() - 1);
        expected_events.push_back(evs[k]);
      end
    endfunction

    function void report(string why, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("event error (%s): want ch %0d act %0d val %h run %0d last %0d, got ch %0d act %0d val %h run %0d last %0d",
                 why, want.channel, want.action, want.drive_value, want.running, want.last,
                 got.channel, got.action, got.drive_value, got.running, got.last);
    endfunction

    // accepted result transfer
    function void check_event(out_item_t got);
      out_item_t want;
      if (expected_events.size() == 0) begin
        report("unexpected", '0, got);
        return;
      end
      want = expected_events.pop_front();
      if (got.channel !== want.channel) report("channel", want, got);
      else if (got.action !== want.action) report("action", want, got);
      else if (got.drive_value !== want.drive_value) report("drive value", want, got);
      else if (got.running !== want.running) report("running", want, got);
      else if (got.last !== want.last) report("last", want, got);
    endfunction

    function int unsigned outstanding();
      return expected_events.size();
    endfunction
  endclass

endpackage

// ===== dv/tb_multichannel_pulse_train_generator_top.sv =====
// testbench top for the multichannel pulse train generator
module tb_multichannel_pulse_train_generator_top;
  import mptg_pkg::*;
  import mptg_tb_pkg::*;

  localparam int QUIET_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int PHASE_ITEMS    = 17;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_item_t    item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   result;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request = 0;

  pulse_event_scoreboard sb = new();

  always #6 clk = ~clk;

  multichannel_pulse_train_generator_top uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // offer one tick and wait for its transfer
  task automatic send_tick(logic [1:0] cmd, bit rs);
    in_item_t tick;
    tick.command = cmd;
    tick.restart = rs;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    push <= 1'b1;
    item <= tick;
    do @(posedge clk); while (full);
    sb.note_tick(tick);
  endtask

  // stop offering and wait until every expected event has come
  task automatic settle(int unsigned quiet);
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (quiet) @(posedge clk);
  endtask

  // register write, write enable stays high across a group
  task automatic put_reg(logic [2:0] idx, logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.note_config(idx, data);
  endtask

  task automatic program_regs(logic [63:0] zf, logic [63:0] act, logic [63:0] zs,
                              logic [63:0] bd, logic [63:0] amp, logic [63:0] en);
    put_reg(REG_ZERO_FIRST, zf);
    put_reg(REG_ACTIVE, act);
    put_reg(REG_ZERO_SECOND, zs);
    put_reg(REG_BURST, bd);
    put_reg(REG_AMPLITUDE, amp);
    put_reg(REG_ENABLE, en);
    cfg_write <= 1'b0;
  endtask

  // short phase times mostly, now and then a full-scale lane
  task automatic random_regs();
    logic [63:0] zf, act, zs, bd, amp;
    logic [3:0]  en;
    for (int c = 0; c < CHANNELS; c++) begin
      zf[16*c +: 16]  = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 5));
      act[16*c +: 16] = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 5));
      zs[16*c +: 16]  = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 5));
      bd[16*c +: 16]  = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 40));
      amp[16*c +: 16] = 16'($urandom_range(0, 65535));
    end
    en = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'hF;
    program_regs(zf, act, zs, bd, amp, 64'(en));
  endtask

  // mostly start / run / stop sequences, some random noise
  task automatic random_phase(int unsigned n_items, bit pause_midway);
    int unsigned sent;
    int unsigned len;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (pause_midway && !paused && sent >= n_items / 2) begin
        settle(1);
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        send_tick(CMD_START, $urandom_range(0, 3) == 0);
        sent++;
        len = $urandom_range(3, 12);
        repeat (len) begin
          send_tick(($urandom_range(0, 9) == 0) ? CMD_SPARE : CMD_TICK,
                    $urandom_range(0, 19) == 0);
          sent++;
        end
        if ($urandom_range(0, 2) != 0) begin
          send_tick(CMD_STOP, $urandom_range(0, 4) == 0);
          send_tick(CMD_TICK, 1'b0);
          sent += 2;
        end
      end else begin
        send_tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // result side: random stalls plus an occasional long hold-off
  initial begin : result_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) sb.check_event(result);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no transfer
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // main sequence
  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset register values: zero bursts, so a start expires at once
    send_tick(CMD_TICK, 1'b0);
    send_tick(CMD_START, 1'b0);
    send_tick(CMD_TICK, 1'b0);
    send_tick(CMD_TICK, 1'b0);
    send_tick(CMD_SPARE, 1'b0);
    send_tick(CMD_STOP, 1'b1);
    send_tick(CMD_TICK, 1'b0);
    settle(QUIET_CYCLES);

    // short periods, one zero-length period, channel 3 disabled
    program_regs({16'd2, 16'd0, 16'd0, 16'd1},
                 {16'd0, 16'd0, 16'd1, 16'd2},
                 {16'd2, 16'd0, 16'd0, 16'd1},
                 {16'd9, 16'd4, 16'd6, 16'd12},
                 {16'h1234, 16'h8000, 16'h0001, 16'hFFFF},
                 64'h7);
    send_tick(CMD_START, 1'b0);
    repeat (4) send_tick(CMD_TICK, 1'b0);
    send_tick(CMD_SPARE, 1'b0);
    send_tick(CMD_TICK, 1'b1);
    repeat (3) send_tick(CMD_TICK, 1'b0);
    send_tick(CMD_STOP, 1'b0);
    send_tick(CMD_TICK, 1'b0);
    send_tick(CMD_START, 1'b1);
    repeat (2) send_tick(CMD_TICK, 1'b0);
    send_tick(CMD_STOP, 1'b0);
    send_tick(CMD_TICK, 1'b0);

    // random phases under each idling pattern
    for (int k = 0; k < 5; k++) begin
      settle(QUIET_CYCLES);
      case (k)
        1: program_regs('1, '1, '1, '1, '1, 64'hF);
        3: program_regs('0, '0, '0, '0, '0, 64'h0);
        default: random_regs();
      endcase
      case (k % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct  = 35;
          recv_stall_pct = 35;
        end
      endcase
      // long result-side hold-off while ticks keep coming
      if (k == 0) hold_request = HOLD_CYCLES;
      random_phase(PHASE_ITEMS, k == 2);
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle(QUIET_CYCLES);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
